// ===== src/sia_pkg.sv =====
// shared opcodes, status codes and default sizes of the script integer alu
`timescale 1ns / 1ps
package sia_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_REM  = 4'd4,
        OP_POW  = 4'd5,
        OP_FPOW = 4'd6,
        OP_EQ   = 4'd7,
        OP_NE   = 4'd8,
        OP_GT   = 4'd9,
        OP_LT   = 4'd10,
        OP_GE   = 4'd11,
        OP_LE   = 4'd12,
        OP_NEG  = 4'd13
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_UNSUP = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

endpackage

// ===== src/sia_if.sv =====
// request and response stream interfaces of the script integer alu
`timescale 1ns / 1ps
interface sia_req_if #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [3:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] left_operand;
    logic signed [DATA_WIDTH-1:0] right_operand;

    modport source (output valid, req_type, left_operand, right_operand, input ready);
    modport sink (input valid, req_type, left_operand, right_operand, output ready);
endinterface

interface sia_rsp_if #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [1:0]                   status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface

// ===== src/script_integer_alu.sv =====
// top level: pipelined signed integer alu with divide and integer power
// path: entry register, then the divide and power stages, then the response register
// throughput: one transaction per cycle; the pipeline stalls as a whole only
//   while the response register is full and not taken
// reset: i_rst_n synchronous active low clears all stage valid bits
`timescale 1ns / 1ps
module script_integer_alu #(
    parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sia_req_if.sink   i_req,
    sia_rsp_if.source o_rsp
);

    localparam int W  = DATA_WIDTH;
    localparam int E  = $clog2(W);          // exponent bits that can avoid saturation
    localparam int H  = (W + 1) / 2;        // half width of a partial product operand
    localparam int PW = 4 * H;              // full product width
    localparam int L  = (W > 4 * E) ? W : 4 * E;

    localparam logic [W-1:0] ONE     = W'(1);
    localparam logic [W-1:0] MAXV    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV    = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] WIDTH_U = W'(W);

    typedef logic [3:0][2*H-1:0] t_pp;

    typedef struct packed {
        sia_pkg::t_op     op;
        logic [W-1:0]     res;      // result of the operations that need neither the divider nor the power loop
        sia_pkg::t_status st;
        logic             dv;       // divider active
        logic [W-1:0]     dvd;
        logic [W-1:0]     dvs;
        logic [W-1:0]     rem;
        logic [W-1:0]     quo;
        logic             qneg;
        logic             rneg;
        logic             pw;       // power loop active
        logic [W-1:0]     acc;
        logic [W-1:0]     mb;
        logic             sat;
        logic [E-1:0]     ex;
        logic             pneg;
        t_pp              pp;       // partial products between multiply stages
    } t_stage;

    // four half-width partial products of an unsigned product
    function automatic t_pp f_pp(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [2*H-1:0] xe;
        logic [2*H-1:0] ye;
        t_pp            p;
        xe = (2*H)'(x);
        ye = (2*H)'(y);
        p[0] = xe[H-1:0] * ye[H-1:0];
        p[1] = xe[2*H-1:H] * ye[H-1:0];
        p[2] = xe[H-1:0] * ye[2*H-1:H];
        p[3] = xe[2*H-1:H] * ye[2*H-1:H];
        return p;
    endfunction

    function automatic logic [PW-1:0] f_sum(input t_pp p);
        return PW'(p[0]) + (PW'(p[1]) << H) + (PW'(p[2]) << H) + (PW'(p[3]) << (2*H));
    endfunction

    function automatic logic [W-1:0] f_sign(input logic [W-1:0] mag, input logic neg);
        return neg ? (W'(0) - mag) : mag;
    endfunction

    logic   en;
    logic   r_vld [0:L];
    t_stage r_stg [0:L];
    t_stage n_stg [0:L];

    logic             r_out_vld;
    logic [W-1:0]     r_out_res;
    sia_pkg::t_status r_out_st;
    logic [W-1:0]     n_out_res;
    sia_pkg::t_status n_out_st;

    // whole pipeline advances unless the response register is held
    assign en          = !r_out_vld || o_rsp.ready;
    assign i_req.ready = en;

    // entry stage: decode, magnitudes, direct results, multiply partials
    always_comb begin
        logic [W-1:0] l;
        logic [W-1:0] r;
        logic [W-1:0] ml;
        logic [W-1:0] mr;
        l  = i_req.left_operand;
        r  = i_req.right_operand;
        ml = f_sign(l, l[W-1]);
        mr = f_sign(r, r[W-1]);
        n_stg[0]      = '0;
        n_stg[0].op   = sia_pkg::t_op'(i_req.req_type);
        n_stg[0].st   = sia_pkg::ST_OK;
        n_stg[0].dvd  = ml;
        n_stg[0].dvs  = mr;
        n_stg[0].qneg = l[W-1] ^ r[W-1];
        n_stg[0].rneg = l[W-1];
        n_stg[0].acc  = ONE;
        n_stg[0].mb   = ml;
        n_stg[0].pneg = l[W-1] & r[0];
        n_stg[0].ex   = r[E-1:0];
        n_stg[0].pp   = f_pp(l, r);
        unique case (sia_pkg::t_op'(i_req.req_type))
            sia_pkg::OP_ADD: n_stg[0].res = l + r;
            sia_pkg::OP_SUB: n_stg[0].res = l - r;
            sia_pkg::OP_MUL: n_stg[0].res = '0;
            sia_pkg::OP_DIV, sia_pkg::OP_REM: begin
                if (r == '0) begin
                    n_stg[0].st = sia_pkg::ST_DIV0;
                end else begin
                    n_stg[0].dv = 1'b1;
                end
            end
            sia_pkg::OP_POW: begin
                priority if (r == '0) begin
                    n_stg[0].res = ONE;
                end else if (ml <= ONE) begin
                    n_stg[0].res = (ml == '0) ? '0 : f_sign(ONE, l[W-1] & r[0]);
                end else if (r[W-1]) begin
                    n_stg[0].res = '0;
                end else if (r >= WIDTH_U) begin
                    // base magnitude of two or more overflows for such exponents
                    n_stg[0].st  = sia_pkg::ST_SAT;
                    n_stg[0].res = (l[W-1] & r[0]) ? MINV : MAXV;
                end else begin
                    n_stg[0].pw = 1'b1;
                end
            end
            sia_pkg::OP_EQ:  n_stg[0].res = {{(W-1){1'b0}}, l == r};
            sia_pkg::OP_NE:  n_stg[0].res = {{(W-1){1'b0}}, l != r};
            sia_pkg::OP_GT:  n_stg[0].res = {{(W-1){1'b0}}, $signed(r) < $signed(l)};
            sia_pkg::OP_LT:  n_stg[0].res = {{(W-1){1'b0}}, $signed(l) < $signed(r)};
            sia_pkg::OP_GE:  n_stg[0].res = {{(W-1){1'b0}}, !($signed(l) < $signed(r))};
            sia_pkg::OP_LE:  n_stg[0].res = {{(W-1){1'b0}}, !($signed(r) < $signed(l))};
            sia_pkg::OP_NEG: n_stg[0].res = W'(0) - r;
            default:         n_stg[0].st  = sia_pkg::ST_UNSUP;
        endcase
    end

    // stage k: one restoring divide bit (k <= W) and one quarter of a power round (k <= 4*E)
    for (genvar k = 1; k <= L; k++) begin : g_stage
        localparam int T  = k - 1;
        localparam int DI = (k <= W) ? (W - k) : 0;
        localparam int EI = (T < 4 * E) ? (E - 1 - T / 4) : 0;
        localparam int SB = T % 4;

        always_comb begin
            logic [W-1:0]  rem_sh;
            logic [PW-1:0] prod;
            logic [PW-1:0] lim;
            n_stg[k] = r_stg[k-1];
            rem_sh   = '0;
            prod     = f_sum(r_stg[k-1].pp);
            lim      = PW'(r_stg[k-1].pneg ? MINV : MAXV);
            // product of the multiply opcode comes out of the first stage
            if (k == 1 && r_stg[k-1].op == sia_pkg::OP_MUL) begin
                n_stg[k].res = prod[W-1:0];
            end
            if (k <= W) begin
                rem_sh = {r_stg[k-1].rem[W-2:0], r_stg[k-1].dvd[DI]};
                if (rem_sh >= r_stg[k-1].dvs) begin
                    n_stg[k].rem     = rem_sh - r_stg[k-1].dvs;
                    n_stg[k].quo[DI] = 1'b1;
                end else begin
                    n_stg[k].rem = rem_sh;
                end
            end
            if (T < 4 * E) begin
                unique case (SB)
                    0: n_stg[k].pp = f_pp(r_stg[k-1].acc, r_stg[k-1].acc);
                    2: n_stg[k].pp = f_pp(r_stg[k-1].acc,
                                          r_stg[k-1].ex[EI] ? r_stg[k-1].mb : ONE);
                    default: begin
                        // growth is monotone, so an early overflow is final
                        n_stg[k].acc = prod[W-1:0];
                        if (prod > lim) begin
                            n_stg[k].sat = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_stg[0] <= n_stg[0];
            for (int k = 1; k <= L; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= L; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_req.valid;
            for (int k = 1; k <= L; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // final selection into the response register
    always_comb begin
        n_out_res = r_stg[L].res;
        n_out_st  = r_stg[L].st;
        if (r_stg[L].dv) begin
            n_out_res = (r_stg[L].op == sia_pkg::OP_DIV) ?
                        f_sign(r_stg[L].quo, r_stg[L].qneg) :
                        f_sign(r_stg[L].rem, r_stg[L].rneg);
        end else if (r_stg[L].pw) begin
            if (r_stg[L].sat) begin
                n_out_res = r_stg[L].pneg ? MINV : MAXV;
                n_out_st  = sia_pkg::ST_SAT;
            end else begin
                n_out_res = f_sign(r_stg[L].acc, r_stg[L].pneg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_res <= n_out_res;
            r_out_st  <= n_out_st;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.result_value = r_out_res;
    assign o_rsp.status       = r_out_st;

    // a divide by zero never leaves a nonzero result
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_st == sia_pkg::ST_DIV0) |-> (r_out_res == '0))
        else $error("divide by zero with nonzero result");

    // a saturated power sits on one of the two limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_st == sia_pkg::ST_SAT) |-> (r_out_res == MAXV || r_out_res == MINV))
        else $error("saturated power off the limits");

    // compares leaving the pipeline carry only 0 or 1
    a_cmp_bool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[L] && (r_stg[L].op == sia_pkg::OP_EQ || r_stg[L].op == sia_pkg::OP_NE ||
                      r_stg[L].op == sia_pkg::OP_GT || r_stg[L].op == sia_pkg::OP_LT ||
                      r_stg[L].op == sia_pkg::OP_GE || r_stg[L].op == sia_pkg::OP_LE))
        |-> (r_stg[L].res[W-1:1] == '0))
        else $error("compare result not boolean");

    // an empty response register never holds off requests
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_req.ready)
        else $error("request stalled with empty output");

endmodule

// ===== bench/script_integer_alu_test.sv =====
// self-checking testbench of the script integer alu: directed cases and random traffic
`timescale 1ns / 1ps
module script_integer_alu_test;

    localparam int DW = 32;
    localparam int LATENCY = 40;          // idle wait at the end, past the block latency
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [DW-1:0] t_word;

    typedef struct packed {
        t_word            value;
        sia_pkg::t_status status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    sia_req_if #(.DATA_WIDTH(DW)) req_bus ();
    sia_rsp_if #(.DATA_WIDTH(DW)) rsp_bus ();

    script_integer_alu #(.DATA_WIDTH(DW)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus.sink),
        .o_rsp  (rsp_bus.source)
    );

    // answers still owed by the block, oldest first
    t_answer answer_queue[$];
    int      fail_count;
    longint  cycle_count;
    int      answers_seen;
    int      op_seen[16];

    localparam t_word WMAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_word WMIN = {1'b1, {(DW-1){1'b0}}};

    // clock, with a cycle counter acting as watchdog
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[script_integer_alu] ERROR");
            $finish;
        end
    end

    // integer power with saturation, worked out on magnitudes
    function automatic t_answer calc_power(t_word base, t_word ex);
        t_answer ans;
        logic [DW-1:0] mb;
        logic [DW-1:0] lim;
        logic [DW:0]   acc;
        logic          neg;
        logic          stop;
        longint        n;
        ans.status = sia_pkg::ST_OK;
        mb = base[DW-1] ? -base : base;
        neg = base[DW-1] & ex[0];
        if (ex == 0) begin
            ans.value = 1;
        end else if (mb <= 1) begin
            ans.value = (mb == 0) ? t_word'(0) : (neg ? t_word'(-1) : t_word'(1));
        end else if (ex[DW-1]) begin
            ans.value = 0;
        end else begin
            lim = neg ? WMIN : WMAX;
            acc = 1;
            stop = 1'b0;
            n = ex;
            // mb >= 2 so at most DW multiplications before overflow
            while (n > 0 && !stop) begin
                if (acc > lim / mb) begin
                    stop = 1'b1;
                end else begin
                    acc = acc * mb;
                    n--;
                end
            end
            if (stop) begin
                ans.value = neg ? WMIN : WMAX;
                ans.status = sia_pkg::ST_SAT;
            end else begin
                ans.value = neg ? -t_word'(acc[DW-1:0]) : t_word'(acc[DW-1:0]);
            end
        end
        return ans;
    endfunction

    // expected result of one request
    function automatic t_answer calc_answer(logic [3:0] op, t_word l, t_word r);
        t_answer ans;
        logic [DW-1:0] ml;
        logic [DW-1:0] mr;
        logic [DW-1:0] q;
        ans.value = 0;
        ans.status = sia_pkg::ST_OK;
        ml = l[DW-1] ? -l : l;
        mr = r[DW-1] ? -r : r;
        case (op)
            sia_pkg::OP_ADD: ans.value = l + r;
            sia_pkg::OP_SUB: ans.value = l - r;
            sia_pkg::OP_MUL: ans.value = l * r;
            sia_pkg::OP_DIV, sia_pkg::OP_REM: begin
                if (r == 0) begin
                    ans.status = sia_pkg::ST_DIV0;
                end else if (op == sia_pkg::OP_DIV) begin
                    q = ml / mr;
                    ans.value = (l[DW-1] != r[DW-1]) ? -q : q;
                end else begin
                    q = ml % mr;
                    ans.value = l[DW-1] ? -q : q;
                end
            end
            sia_pkg::OP_POW: ans = calc_power(l, r);
            sia_pkg::OP_EQ:  ans.value = (l == r);
            sia_pkg::OP_NE:  ans.value = (l != r);
            sia_pkg::OP_GT:  ans.value = (l > r);
            sia_pkg::OP_LT:  ans.value = (l < r);
            sia_pkg::OP_GE:  ans.value = (l >= r);
            sia_pkg::OP_LE:  ans.value = (l <= r);
            sia_pkg::OP_NEG: ans.value = -r;
            default: ans.status = sia_pkg::ST_UNSUP;
        endcase
        return ans;
    endfunction

    // random gap length: mostly short, sometimes long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // send one request transaction, then an idle gap if one is asked for
    task automatic send_request(logic [3:0] op, t_word l, t_word r, int gap);
        req_bus.valid <= 1'b1;
        req_bus.req_type <= op;
        req_bus.left_operand <= l;
        req_bus.right_operand <= r;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        answer_queue.push_back(calc_answer(op, l, r));
        op_seen[op]++;
        @(negedge i_clk);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drop_valid();
        req_bus.valid <= 1'b0;
    endtask

    // hold off until every owed answer has come
    task automatic wait_drained();
        drop_valid();
        while (answer_queue.size() != 0) @(negedge i_clk);
    endtask

    // response ready with random stalls
    int stall_left;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) stall_left <= pick_gap();
        end
    end

    // compare each response transaction with the oldest owed answer
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            answers_seen++;
            if (answer_queue.size() == 0) begin
                $error("response with no request pending: value %0d status %0d",
                       rsp_bus.result_value, rsp_bus.status);
                fail_count++;
            end else begin
                want = answer_queue.pop_front();
                if (rsp_bus.result_value !== want.value) begin
                    $error("result_value: expected %0d, actual %0d",
                           want.value, rsp_bus.result_value);
                    fail_count++;
                end
                if (rsp_bus.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                    fail_count++;
                end
            end
        end
    end

    // random operand biased toward edges and small values
    function automatic t_word pick_operand();
        case ($urandom_range(0, 7))
            0: return WMAX;
            1: return WMIN;
            2: return t_word'($urandom_range(0, 4)) - 2;
            3: return t_word'($urandom_range(0, 40)) - 20;
            default: return t_word'($urandom);
        endcase
    endfunction

    // directed corners: every opcode and each special case
    task automatic test_directed();
        logic [3:0] op;
        for (int k = 0; k < 16; k++) begin
            op = 4'(k);
            send_request(op, 32'sd7, -32'sd3, 0);
        end
        send_request(sia_pkg::OP_DIV, WMIN, -1, 0);
        send_request(sia_pkg::OP_REM, WMIN, -1, 1);
        send_request(sia_pkg::OP_DIV, 5, 0, 0);
        send_request(sia_pkg::OP_REM, -5, 0, 0);
        send_request(sia_pkg::OP_POW, 2, 31, 0);      // saturates
        send_request(sia_pkg::OP_POW, -2, 31, 0);     // exactly the minimum
        send_request(sia_pkg::OP_POW, 0, 0, 2);       // zero exponent
        send_request(sia_pkg::OP_POW, -1, -7, 0);     // negative exponent, odd
        send_request(sia_pkg::OP_POW, 3, -2, 0);
        send_request(sia_pkg::OP_ADD, WMAX, WMAX, 0);
        send_request(sia_pkg::OP_NEG, 0, WMIN, 0);
    endtask

    // random traffic over all opcodes, with small power operands most of the time
    task automatic test_random(int count);
        logic [3:0] op;
        t_word l;
        t_word r;
        for (int n = 0; n < count; n++) begin
            op = 4'($urandom_range(0, 15));
            l = pick_operand();
            r = pick_operand();
            if (op == sia_pkg::OP_POW && $urandom_range(0, 3) != 0) begin
                l = t_word'($urandom_range(0, 20)) - 10;
                r = t_word'($urandom_range(0, 40)) - 4;
            end
            if (op >= sia_pkg::OP_EQ && op <= sia_pkg::OP_LE && $urandom_range(0, 3) == 0) r = l;
            send_request(op, l, r, pick_gap());
            if (n == count / 2) wait_drained();
        end
    endtask

    // back to back with no idling on the request side
    task automatic test_burst(int count);
        for (int n = 0; n < count; n++)
            send_request(4'($urandom_range(0, 15)), pick_operand(), pick_operand(), 0);
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        answers_seen = 0;
        stall_left = 0;
        foreach (op_seen[k]) op_seen[k] = 0;
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.req_type = '0;
        req_bus.left_operand = '0;
        req_bus.right_operand = '0;
        rsp_bus.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(1200);
        test_burst(300);
        wait_drained();
        repeat (LATENCY) @(negedge i_clk);

        $display("covered %0d responses over 16 opcodes (add seen %0d, pow seen %0d)",
                 answers_seen, op_seen[sia_pkg::OP_ADD], op_seen[sia_pkg::OP_POW]);
        if (fail_count == 0 && answer_queue.size() == 0) begin
            $display("[script_integer_alu] OK");
        end else begin
            $display("[script_integer_alu] ERROR");
        end
        $finish;
    end
endmodule
